// ----- hw/rtl/bai_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the BAI index stream parser.
// No dependencies; imported by every module of the block.
package bai_pkg;

    // Parser phase: which field of the index the next byte belongs to.
    typedef enum logic [3:0] {
        PH_HEADER,
        PH_BIN_COUNT,
        PH_BIN_ID,
        PH_CHK_COUNT,
        PH_CHK_BEGIN,
        PH_CHK_END,
        PH_INT_COUNT,
        PH_LINEAR,
        PH_UNPLACED,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef logic [3:0] t_kind;
    localparam t_kind KIND_REF_COUNT = 4'd0;
    localparam t_kind KIND_BIN_COUNT = 4'd1;
    localparam t_kind KIND_BIN_HDR   = 4'd2;
    localparam t_kind KIND_CHK_BEGIN = 4'd3;
    localparam t_kind KIND_CHK_END   = 4'd4;
    localparam t_kind KIND_INT_COUNT = 4'd5;
    localparam t_kind KIND_LINEAR    = 4'd6;
    localparam t_kind KIND_UNPLACED  = 4'd7;
    localparam t_kind KIND_FINAL     = 4'd8;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_TRUNC     = 3'd1;
    localparam t_status ST_BAD_MAGIC = 3'd2;
    localparam t_status ST_NEG_REF   = 3'd3;
    localparam t_status ST_NEG_BIN   = 3'd4;
    localparam t_status ST_NEG_CHUNK = 3'd5;
    localparam t_status ST_NEG_INT   = 3'd6;
    localparam t_status ST_TRAILING  = 3'd7;

    // One input beat.
    typedef struct packed {
        logic       mode;       // 1 = end of file
        logic [7:0] data_byte;
    } t_beat;

    // One output record.
    typedef struct packed {
        t_kind       record_kind;
        logic [30:0] ref_index;
        logic [30:0] item_index;
        logic [31:0] bin_number;
        logic [63:0] field_value;
        t_status     status;
    } t_rec;

    // Expected magic "BAI\1", one byte per header position.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = 8'h42;
            2'd1:    b = 8'h41;
            2'd2:    b = 8'h49;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/bai_in_reg.sv -----
`timescale 1ns / 1ps
// Input register stage of the BAI index parser: holds one beat for the core.
// Depends on bai_pkg.
module bai_in_reg
    import bai_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_beat i_beat,
    input  logic  i_advance,
    output logic  o_valid,
    output t_beat o_beat
);

    logic  r_valid;
    t_beat r_beat;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

endmodule

// ----- hw/rtl/bai_parse_core.sv -----
`timescale 1ns / 1ps
// Parser core of the BAI index parser: field assembly, nesting counters, phase
// machine and record formation, one byte per cycle with i_take. Depends on bai_pkg.
module bai_parse_core
    import bai_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_beat i_beat,
    output logic  o_emit,
    output t_rec  o_rec
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [63:0] r_field, n_field;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic        r_magic_ok, n_magic_ok;
    logic [30:0] r_refs_left, n_refs_left;
    logic [30:0] r_bins_left, n_bins_left;
    logic [30:0] r_chunks_left, n_chunks_left;
    logic [30:0] r_ints_left, n_ints_left;
    logic [30:0] r_cur_ref, n_cur_ref;
    logic [30:0] r_cur_item, n_cur_item;
    logic [30:0] r_bin_item, n_bin_item;
    logic [31:0] r_cur_bin, n_cur_bin;
    t_status     r_sticky, n_sticky;

    logic [63:0] w_field;
    logic        w_long;
    logic        w_done;
    logic        w_magic_ok;
    logic [31:0] w_v32;
    logic        w_neg;
    logic [30:0] w_refs_dec, w_bins_dec, w_chunks_dec, w_ints_dec;
    t_status     w_eof_status;

    // Assembled field including the incoming byte.
    always_comb begin
        w_field = r_field;
        if (r_phase == PH_HEADER) begin
            if (r_hdr_cnt[2]) begin
                w_field[r_hdr_cnt[1:0]*8 +: 8] = i_beat.data_byte;
            end
        end else begin
            w_field[r_pos*8 +: 8] = i_beat.data_byte;
        end
    end

    assign w_long = r_phase inside {PH_CHK_BEGIN, PH_CHK_END, PH_LINEAR, PH_UNPLACED};
    assign w_done = (r_phase == PH_HEADER) ? (r_hdr_cnt == 3'd7)
                  : (r_pos == (w_long ? 3'd7 : 3'd3));
    assign w_magic_ok = r_magic_ok &&
                        (r_hdr_cnt[2] || (i_beat.data_byte == magic_byte(r_hdr_cnt[1:0])));
    assign w_v32 = w_field[31:0];
    assign w_neg = w_v32[31];

    assign w_refs_dec   = (r_refs_left   != '0) ? r_refs_left   - 31'd1 : r_refs_left;
    assign w_bins_dec   = (r_bins_left   != '0) ? r_bins_left   - 31'd1 : r_bins_left;
    assign w_chunks_dec = (r_chunks_left != '0) ? r_chunks_left - 31'd1 : r_chunks_left;
    assign w_ints_dec   = (r_ints_left   != '0) ? r_ints_left   - 31'd1 : r_ints_left;

    assign w_eof_status = (r_sticky != ST_OK) ? r_sticky
                        : ((r_pos != 3'd0) ||
                           !(r_phase == PH_UNPLACED || r_phase == PH_DONE)) ? ST_TRUNC
                        : ST_OK;

    // Next state.
    always_comb begin
        n_phase       = r_phase;
        n_pos         = r_pos;
        n_field       = r_field;
        n_hdr_cnt     = r_hdr_cnt;
        n_magic_ok    = r_magic_ok;
        n_refs_left   = r_refs_left;
        n_bins_left   = r_bins_left;
        n_chunks_left = r_chunks_left;
        n_ints_left   = r_ints_left;
        n_cur_ref     = r_cur_ref;
        n_cur_item    = r_cur_item;
        n_bin_item    = r_bin_item;
        n_cur_bin     = r_cur_bin;
        n_sticky      = r_sticky;

        if (i_take) begin
            if (i_beat.mode) begin
                n_phase       = PH_HEADER;
                n_pos         = '0;
                n_field       = '0;
                n_hdr_cnt     = '0;
                n_magic_ok    = 1'b1;
                n_refs_left   = '0;
                n_bins_left   = '0;
                n_chunks_left = '0;
                n_ints_left   = '0;
                n_cur_ref     = '0;
                n_cur_item    = '0;
                n_bin_item    = '0;
                n_cur_bin     = '0;
                n_sticky      = ST_OK;
            end else if (r_phase == PH_HEADER) begin
                n_field    = w_field;
                n_hdr_cnt  = r_hdr_cnt + 3'd1;
                n_magic_ok = w_magic_ok;
                if (w_done) begin
                    n_field = '0;
                    if (!w_magic_ok) begin
                        n_sticky = ST_BAD_MAGIC;
                        n_phase  = PH_ERROR;
                    end else if (w_neg) begin
                        n_sticky = ST_NEG_REF;
                        n_phase  = PH_ERROR;
                    end else begin
                        n_refs_left = w_v32[30:0];
                        n_cur_ref   = '0;
                        n_phase     = (w_v32 != '0) ? PH_BIN_COUNT : PH_UNPLACED;
                    end
                end
            end else if (r_phase == PH_DONE) begin
                n_sticky = ST_TRAILING;
                n_phase  = PH_ERROR;
            end else if (r_phase != PH_ERROR) begin
                n_field = w_field;
                n_pos   = r_pos + 3'd1;
                if (w_done) begin
                    n_pos   = '0;
                    n_field = '0;
                    unique case (r_phase)
                        PH_BIN_COUNT: begin
                            if (w_neg) begin
                                n_sticky = ST_NEG_BIN;
                                n_phase  = PH_ERROR;
                            end else begin
                                n_bins_left = w_v32[30:0];
                                n_bin_item  = '0;
                                n_phase     = (w_v32 != '0) ? PH_BIN_ID : PH_INT_COUNT;
                            end
                        end
                        PH_BIN_ID: begin
                            n_cur_bin = w_v32;
                            n_phase   = PH_CHK_COUNT;
                        end
                        PH_CHK_COUNT: begin
                            if (w_neg) begin
                                n_sticky = ST_NEG_CHUNK;
                                n_phase  = PH_ERROR;
                            end else begin
                                n_chunks_left = w_v32[30:0];
                                n_cur_item    = '0;
                                if (w_v32 != '0) begin
                                    n_phase = PH_CHK_BEGIN;
                                end else begin
                                    // bin without chunks: close it now
                                    n_bins_left = w_bins_dec;
                                    n_bin_item  = r_bin_item + 31'd1;
                                    n_phase     = (w_bins_dec != '0) ? PH_BIN_ID
                                                                     : PH_INT_COUNT;
                                end
                            end
                        end
                        PH_CHK_BEGIN: begin
                            n_phase = PH_CHK_END;
                        end
                        PH_CHK_END: begin
                            n_chunks_left = w_chunks_dec;
                            n_cur_item    = r_cur_item + 31'd1;
                            if (w_chunks_dec != '0) begin
                                n_phase = PH_CHK_BEGIN;
                            end else begin
                                n_bins_left = w_bins_dec;
                                n_bin_item  = r_bin_item + 31'd1;
                                n_phase     = (w_bins_dec != '0) ? PH_BIN_ID : PH_INT_COUNT;
                            end
                        end
                        PH_INT_COUNT: begin
                            if (w_neg) begin
                                n_sticky = ST_NEG_INT;
                                n_phase  = PH_ERROR;
                            end else begin
                                n_ints_left = w_v32[30:0];
                                n_cur_item  = '0;
                                if (w_v32 != '0) begin
                                    n_phase = PH_LINEAR;
                                end else begin
                                    n_refs_left = w_refs_dec;
                                    n_cur_ref   = r_cur_ref + 31'd1;
                                    n_phase     = (w_refs_dec != '0) ? PH_BIN_COUNT
                                                                     : PH_UNPLACED;
                                end
                            end
                        end
                        PH_LINEAR: begin
                            n_ints_left = w_ints_dec;
                            n_cur_item  = r_cur_item + 31'd1;
                            if (w_ints_dec == '0) begin
                                n_refs_left = w_refs_dec;
                                n_cur_ref   = r_cur_ref + 31'd1;
                                n_phase     = (w_refs_dec != '0) ? PH_BIN_COUNT : PH_UNPLACED;
                            end
                        end
                        PH_UNPLACED: begin
                            n_phase = PH_DONE;
                        end
                        default: begin
                            n_phase = PH_ERROR;
                        end
                    endcase
                end
            end
        end
    end

    // Record formed by the beat at the input, if any.
    always_comb begin
        o_emit = 1'b0;
        o_rec  = '0;
        if (i_beat.mode) begin
            o_emit             = 1'b1;
            o_rec.record_kind  = KIND_FINAL;
            o_rec.status       = w_eof_status;
        end else if (w_done) begin
            unique case (r_phase)
                PH_HEADER: begin
                    o_emit = 1'b1;
                    if (!w_magic_ok) begin
                        o_rec.record_kind = KIND_FINAL;
                        o_rec.status      = ST_BAD_MAGIC;
                    end else begin
                        o_rec.record_kind = KIND_REF_COUNT;
                        o_rec.field_value = {32'd0, w_v32};
                        o_rec.status      = w_neg ? ST_NEG_REF : ST_OK;
                    end
                end
                PH_BIN_COUNT: begin
                    o_emit            = 1'b1;
                    o_rec.record_kind = KIND_BIN_COUNT;
                    o_rec.ref_index   = r_cur_ref;
                    o_rec.field_value = {32'd0, w_v32};
                    o_rec.status      = w_neg ? ST_NEG_BIN : ST_OK;
                end
                PH_CHK_COUNT: begin
                    o_emit            = 1'b1;
                    o_rec.record_kind = KIND_BIN_HDR;
                    o_rec.ref_index   = r_cur_ref;
                    o_rec.item_index  = r_bin_item;
                    o_rec.bin_number  = r_cur_bin;
                    o_rec.field_value = {32'd0, w_v32};
                    o_rec.status      = w_neg ? ST_NEG_CHUNK : ST_OK;
                end
                PH_CHK_BEGIN, PH_CHK_END: begin
                    o_emit            = 1'b1;
                    o_rec.record_kind = (r_phase == PH_CHK_BEGIN) ? KIND_CHK_BEGIN
                                                                  : KIND_CHK_END;
                    o_rec.ref_index   = r_cur_ref;
                    o_rec.item_index  = r_cur_item;
                    o_rec.bin_number  = r_cur_bin;
                    o_rec.field_value = w_field;
                end
                PH_INT_COUNT: begin
                    o_emit            = 1'b1;
                    o_rec.record_kind = KIND_INT_COUNT;
                    o_rec.ref_index   = r_cur_ref;
                    o_rec.field_value = {32'd0, w_v32};
                    o_rec.status      = w_neg ? ST_NEG_INT : ST_OK;
                end
                PH_LINEAR: begin
                    o_emit            = 1'b1;
                    o_rec.record_kind = KIND_LINEAR;
                    o_rec.ref_index   = r_cur_ref;
                    o_rec.item_index  = r_cur_item;
                    o_rec.field_value = w_field;
                end
                PH_UNPLACED: begin
                    o_emit            = 1'b1;
                    o_rec.record_kind = KIND_UNPLACED;
                    o_rec.field_value = w_field;
                end
                default: begin
                    o_emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_pos         <= '0;
            r_field       <= '0;
            r_hdr_cnt     <= '0;
            r_magic_ok    <= 1'b1;
            r_refs_left   <= '0;
            r_bins_left   <= '0;
            r_chunks_left <= '0;
            r_ints_left   <= '0;
            r_cur_ref     <= '0;
            r_cur_item    <= '0;
            r_bin_item    <= '0;
            r_cur_bin     <= '0;
            r_sticky      <= ST_OK;
        end else begin
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_field       <= n_field;
            r_hdr_cnt     <= n_hdr_cnt;
            r_magic_ok    <= n_magic_ok;
            r_refs_left   <= n_refs_left;
            r_bins_left   <= n_bins_left;
            r_chunks_left <= n_chunks_left;
            r_ints_left   <= n_ints_left;
            r_cur_ref     <= n_cur_ref;
            r_cur_item    <= n_cur_item;
            r_bin_item    <= n_bin_item;
            r_cur_bin     <= n_cur_bin;
            r_sticky      <= n_sticky;
        end
    end

    a_eof_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_beat.mode) |=> (r_phase == PH_HEADER && r_sticky == ST_OK))
        else $error("end of file did not return parser to header phase");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |-> (r_sticky != ST_OK))
        else $error("error phase without sticky status");

    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_pos == 3'd0))
        else $error("byte position moved during header");

    a_short_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BIN_COUNT || r_phase == PH_BIN_ID ||
         r_phase == PH_CHK_COUNT || r_phase == PH_INT_COUNT) |-> (r_pos < 3'd4))
        else $error("byte position overran a 32-bit field");

endmodule

// ----- hw/rtl/bai_out_reg.sv -----
`timescale 1ns / 1ps
// Result register of the BAI index parser: holds one record until taken.
// Depends on bai_pkg.
module bai_out_reg
    import bai_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_rec i_rec,
    output logic o_free,
    output logic o_valid,
    input  logic i_ready,
    output t_rec o_rec
);

    logic r_valid;
    t_rec r_rec;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= i_rec;
        end
    end

endmodule

// ----- hw/rtl/bai_index_stream_parser.sv -----
`timescale 1ns / 1ps
// Top level of the BAI index stream parser.
// Depends on bai_pkg, bai_in_reg, bai_parse_core and bai_out_reg.

// Accepts a BAI index one byte per beat (mode 0) and an end-of-file beat
// (mode 1), and emits one record per completed field of interest: reference
// count, bin count, bin header (id plus chunk count), chunk begin/end, interval
// count, linear offset, unplaced count, and a final status on end of file.
// Throughput is one beat per cycle when not stalled: each beat is handled by
// the parser core sitting between an input register and a result register,
// and its record is registered in the result register. The only
// stall comes from the result register: a beat that produces a record waits
// in the input register while an earlier record is still untaken; beats that
// produce no record keep flowing. Bad magic is reported on the eighth byte;
// a negative count, trailing data after the unplaced count, or bad magic
// parks the parser, which then drops data bytes until end of file. End of file
// reports the sticky error, or truncation if the stream stopped mid-field or
// mid-structure, and returns the parser to its reset state.
module bai_index_stream_parser
    import bai_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    // record channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_record_kind,
    output logic [30:0] o_ref_index,
    output logic [30:0] o_item_index,
    output logic [31:0] o_bin_number,
    output logic [63:0] o_field_value,
    output logic [2:0]  o_status
);

    t_beat w_in_beat;
    t_beat w_q_beat;
    logic  w_q_valid;
    logic  w_advance;
    logic  w_emit;
    t_rec  w_rec;
    t_rec  w_out_rec;
    logic  w_out_free;

    assign w_in_beat.mode      = i_mode;
    assign w_in_beat.data_byte = i_data_byte;

    // Advance the held beat unless it makes a record and the result slot is busy.
    assign w_advance = w_q_valid && (!w_emit || w_out_free);

    bai_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_beat    (w_in_beat),
        .i_advance (w_advance),
        .o_valid   (w_q_valid),
        .o_beat    (w_q_beat)
    );

    bai_parse_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_advance),
        .i_beat  (w_q_beat),
        .o_emit  (w_emit),
        .o_rec   (w_rec)
    );

    bai_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance && w_emit),
        .i_rec   (w_rec),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_rec   (w_out_rec)
    );

    assign o_record_kind = w_out_rec.record_kind;
    assign o_ref_index   = w_out_rec.ref_index;
    assign o_item_index  = w_out_rec.item_index;
    assign o_bin_number  = w_out_rec.bin_number;
    assign o_field_value = w_out_rec.field_value;
    assign o_status      = w_out_rec.status;

endmodule

// ----- tb/bai_record_checker.sv -----
`timescale 1ns / 1ps
// Record checker for the BAI index stream parser: predicts and compares records.
// Depends on bai_pkg for the phase enum, record struct, kind and status codes.
module bai_record_checker
    import bai_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_record_kind,
    input  logic [30:0] i_ref_index,
    input  logic [30:0] i_item_index,
    input  logic [31:0] i_bin_number,
    input  logic [63:0] i_field_value,
    input  logic [2:0]  i_status,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_record_count
);

    // "BAI\1" read as a little-endian word
    localparam logic [31:0] BAI_MAGIC_LE = 32'h0149_4142;

    t_rec pending_records[$];
    int   fail_count    = 0;
    int   pending_count = 0;
    int   record_count  = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending_count;
    assign o_record_count = record_count;

    // parser state as seen from outside
    t_phase      ph;
    logic [2:0]  byte_pos;
    logic [63:0] acc;
    logic [3:0]  hdr_seen;
    logic        magic_ok;
    logic [31:0] refs_left;
    logic [31:0] bins_left;
    logic [31:0] chunks_left;
    logic [31:0] ints_left;
    logic [30:0] cur_ref;
    logic [30:0] cur_item;
    logic [30:0] cur_bin_idx;
    logic [31:0] cur_bin;
    t_status     sticky;

    task automatic clear_parser();
        ph          = PH_HEADER;
        byte_pos    = '0;
        acc         = '0;
        hdr_seen    = '0;
        magic_ok    = 1'b1;
        refs_left   = '0;
        bins_left   = '0;
        chunks_left = '0;
        ints_left   = '0;
        cur_ref     = '0;
        cur_item    = '0;
        cur_bin_idx = '0;
        cur_bin     = '0;
        sticky      = ST_OK;
    endtask

    task automatic push_rec(input t_kind kind, input logic [30:0] ref_i,
                            input logic [30:0] item_i, input logic [31:0] bin,
                            input logic [63:0] val, input t_status st);
        t_rec r;
        r.record_kind = kind;
        r.ref_index   = ref_i;
        r.item_index  = item_i;
        r.bin_number  = bin;
        r.field_value = val;
        r.status      = st;
        pending_records = {pending_records, r};
    endtask

    // Latch the error and park until end of file.
    task automatic park(input t_kind kind, input t_status st, input logic [63:0] val,
                        input logic [30:0] ref_i, input logic [30:0] item_i,
                        input logic [31:0] bin);
        sticky = st;
        ph     = PH_ERROR;
        push_rec(kind, ref_i, item_i, bin, val, st);
    endtask

    task automatic close_ref();
        if (refs_left != 0) refs_left = refs_left - 32'd1;
        cur_ref = cur_ref + 31'd1;
        ph = (refs_left != 0) ? PH_BIN_COUNT : PH_UNPLACED;
    endtask

    task automatic close_bin();
        if (bins_left != 0) bins_left = bins_left - 32'd1;
        cur_bin_idx = cur_bin_idx + 31'd1;
        ph = (bins_left != 0) ? PH_BIN_ID : PH_INT_COUNT;
    endtask

    task automatic parse_beat(input logic mode, input logic [7:0] b);
        logic [2:0]  k;
        logic [2:0]  flen;
        logic [63:0] v;
        logic [31:0] v32;
        t_status     st;
        if (mode) begin
            if (sticky != ST_OK) st = sticky;
            else if (byte_pos != 0 || (ph != PH_UNPLACED && ph != PH_DONE)) st = ST_TRUNC;
            else st = ST_OK;
            push_rec(KIND_FINAL, '0, '0, '0, '0, st);
            clear_parser();
            return;
        end
        if (ph == PH_ERROR) return;
        if (ph == PH_DONE) begin
            sticky = ST_TRAILING;
            ph     = PH_ERROR;
            return;
        end
        if (ph == PH_HEADER) begin
            k = hdr_seen[2:0];
            if (k < 4) begin
                if (b != BAI_MAGIC_LE[8*k +: 8]) magic_ok = 1'b0;
            end else begin
                acc[8*(k-4) +: 8] = b;
            end
            hdr_seen = {1'b0, k} + 4'd1;
            if (k != 3'd7) return;
            v32 = acc[31:0];
            acc = '0;
            if (!magic_ok) begin
                park(KIND_FINAL, ST_BAD_MAGIC, '0, '0, '0, '0);
            end else if (v32[31]) begin
                park(KIND_REF_COUNT, ST_NEG_REF, {32'd0, v32}, '0, '0, '0);
            end else begin
                refs_left = v32;
                cur_ref   = '0;
                ph = (v32 != 0) ? PH_BIN_COUNT : PH_UNPLACED;
                push_rec(KIND_REF_COUNT, '0, '0, '0, {32'd0, v32}, ST_OK);
            end
            return;
        end

        // offsets are 8 bytes (wrapping to 0 in the 3-bit counter), counts and ids 4
        flen = (ph == PH_CHK_BEGIN || ph == PH_CHK_END || ph == PH_LINEAR ||
                ph == PH_UNPLACED) ? 3'd0 : 3'd4;
        acc[8*byte_pos +: 8] = b;
        byte_pos = byte_pos + 3'd1;
        if (byte_pos != flen) return;
        byte_pos = '0;
        v   = acc;
        acc = '0;
        v32 = v[31:0];

        case (ph)
            PH_BIN_COUNT: begin
                if (v32[31]) begin
                    park(KIND_BIN_COUNT, ST_NEG_BIN, {32'd0, v32}, cur_ref, '0, '0);
                end else begin
                    bins_left   = v32;
                    cur_bin_idx = '0;
                    ph = (v32 != 0) ? PH_BIN_ID : PH_INT_COUNT;
                    push_rec(KIND_BIN_COUNT, cur_ref, '0, '0, {32'd0, v32}, ST_OK);
                end
            end
            PH_BIN_ID: begin
                cur_bin = v32;
                ph      = PH_CHK_COUNT;
            end
            PH_CHK_COUNT: begin
                if (v32[31]) begin
                    park(KIND_BIN_HDR, ST_NEG_CHUNK, {32'd0, v32}, cur_ref, cur_bin_idx,
                         cur_bin);
                end else begin
                    push_rec(KIND_BIN_HDR, cur_ref, cur_bin_idx, cur_bin, {32'd0, v32},
                             ST_OK);
                    chunks_left = v32;
                    cur_item    = '0;
                    if (v32 != 0) ph = PH_CHK_BEGIN;
                    else close_bin();
                end
            end
            PH_CHK_BEGIN: begin
                push_rec(KIND_CHK_BEGIN, cur_ref, cur_item, cur_bin, v, ST_OK);
                ph = PH_CHK_END;
            end
            PH_CHK_END: begin
                push_rec(KIND_CHK_END, cur_ref, cur_item, cur_bin, v, ST_OK);
                if (chunks_left != 0) chunks_left = chunks_left - 32'd1;
                cur_item = cur_item + 31'd1;
                if (chunks_left != 0) ph = PH_CHK_BEGIN;
                else close_bin();
            end
            PH_INT_COUNT: begin
                if (v32[31]) begin
                    park(KIND_INT_COUNT, ST_NEG_INT, {32'd0, v32}, cur_ref, '0, '0);
                end else begin
                    push_rec(KIND_INT_COUNT, cur_ref, '0, '0, {32'd0, v32}, ST_OK);
                    ints_left = v32;
                    cur_item  = '0;
                    if (v32 != 0) ph = PH_LINEAR;
                    else close_ref();
                end
            end
            PH_LINEAR: begin
                push_rec(KIND_LINEAR, cur_ref, cur_item, '0, v, ST_OK);
                if (ints_left != 0) ints_left = ints_left - 32'd1;
                cur_item = cur_item + 31'd1;
                if (ints_left == 0) close_ref();
            end
            PH_UNPLACED: begin
                push_rec(KIND_UNPLACED, '0, '0, '0, v, ST_OK);
                ph = PH_DONE;
            end
            default: ph = PH_ERROR;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_rec want;
        if (!i_rst_n) begin
            clear_parser();
            pending_records.delete();
        end else begin
            // compare first: a record never leaves in the cycle its last byte enters
            if (i_out_valid && i_out_ready) begin
                if (pending_records.size() == 0) begin
                    $error("unexpected record: kind %0d status %0d", i_record_kind, i_status);
                    fail_count++;
                end else begin
                    want = pending_records.pop_front();
                    record_count++;
                    if (i_record_kind !== want.record_kind) begin
                        $error("record_kind: expected %0d, actual %0d",
                               want.record_kind, i_record_kind);
                        fail_count++;
                    end
                    if (i_ref_index !== want.ref_index) begin
                        $error("ref_index: expected %0d, actual %0d",
                               want.ref_index, i_ref_index);
                        fail_count++;
                    end
                    if (i_item_index !== want.item_index) begin
                        $error("item_index: expected %0d, actual %0d",
                               want.item_index, i_item_index);
                        fail_count++;
                    end
                    if (i_bin_number !== want.bin_number) begin
                        $error("bin_number: expected %h, actual %h",
                               want.bin_number, i_bin_number);
                        fail_count++;
                    end
                    if (i_field_value !== want.field_value) begin
                        $error("field_value: expected %h, actual %h",
                               want.field_value, i_field_value);
                        fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) parse_beat(i_mode, i_data_byte);
        end
        pending_count = pending_records.size();
    end

endmodule

// ----- tb/tb_bai_index_stream_parser.sv -----
`timescale 1ns / 1ps
// Testbench top for the BAI index stream parser: builds index files and drives beats.
// Depends on the bai_index_stream_parser RTL and on bai_record_checker.
module tb_bai_index_stream_parser;

    localparam int          CLK_PERIOD      = 12;
    localparam int          RX_HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          WATCHDOG_CYCLES = 200_000;
    localparam int          PHASE_BEATS     = 90;
    localparam logic [31:0] BAI_MAGIC_LE    = 32'h0149_4142;

    // Ways to spoil a generated index file.
    typedef enum int {
        FLAW_NONE,
        FLAW_NEG_REF,
        FLAW_NEG_BIN,
        FLAW_NEG_CHUNK,
        FLAW_NEG_INT,
        FLAW_TRUNCATE,
        FLAW_TRAILING,
        FLAW_MAGIC,
        FLAW_HUGE_COUNT,
        FLAW_NOISE
    } t_flaw;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        in_mode;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  rec_kind;
    logic [30:0] rec_ref;
    logic [30:0] rec_item;
    logic [31:0] rec_bin;
    logic [63:0] rec_value;
    logic [2:0]  rec_status;

    int   fail_count;
    int   pending;
    int   records_seen;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   beats_sent  = 0;
    int   files_sent  = 0;
    logic hold_rx_req = 1'b0;

    logic [7:0] file_bytes[$];

    always #(CLK_PERIOD / 2) clk = ~clk;

    bai_index_stream_parser u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_mode        (in_mode),
        .i_data_byte   (in_byte),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_record_kind (rec_kind),
        .o_ref_index   (rec_ref),
        .o_item_index  (rec_item),
        .o_bin_number  (rec_bin),
        .o_field_value (rec_value),
        .o_status      (rec_status)
    );

    bai_record_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_mode         (in_mode),
        .i_data_byte    (in_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_record_kind  (rec_kind),
        .i_ref_index    (rec_ref),
        .i_item_index   (rec_item),
        .i_bin_number   (rec_bin),
        .i_field_value  (rec_value),
        .i_status       (rec_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_record_count (records_seen)
    );

    // Offer one beat and hold it until the parser takes it. Idle cycles drop
    // valid first; when no idle is drawn, valid stays high straight into the
    // next beat, so each signal gets a single assignment per edge.
    task automatic send_beat(input logic mode, input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    // Stream the assembled file, then the end-of-file beat with a random
    // don't-care byte so the data lines keep toggling.
    task automatic send_file();
        int i;
        for (i = 0; i < file_bytes.size(); i++) send_beat(1'b0, file_bytes[i]);
        send_beat(1'b1, 8'($urandom));
        files_sent++;
    endtask

    // Append one byte to the file under construction.
    task automatic add_byte(input logic [7:0] b);
        file_bytes = {file_bytes, b};
    endtask

    task automatic put_le(input logic [63:0] v, input int n);
        int i;
        for (i = 0; i < n; i++) add_byte(v[8*i +: 8]);
    endtask

    task automatic put_noise(input int max_len);
        int i;
        int n;
        n = $urandom_range(0, max_len);
        for (i = 0; i < n; i++) add_byte(8'($urandom));
    endtask

    // Assemble a small random index. A negative-count flaw stops the file at
    // the first count of that kind and tails it with garbage the parser must drop.
    task automatic build_index(input t_flaw flaw);
        int r;
        int bn;
        int c;
        int n_refs;
        int n_bins;
        int n_chunks;
        int n_ints;
        logic [31:0] neg_count;
        file_bytes.delete();
        neg_count = {1'b1, 31'($urandom)};
        put_le(BAI_MAGIC_LE, 4);
        n_refs = $urandom_range(0, 3);
        if (flaw == FLAW_NEG_REF) begin
            put_le(neg_count, 4);
            put_noise(6);
            return;
        end
        // a count far above what follows leaves the file short of references
        put_le((flaw == FLAW_HUGE_COUNT) ? 32'h7FFF_FFFF : n_refs, 4);
        for (r = 0; r < n_refs; r++) begin
            n_bins = $urandom_range(0, 3);
            if (flaw == FLAW_NEG_BIN) begin
                put_le(neg_count, 4);
                put_noise(6);
                return;
            end
            put_le(n_bins, 4);
            for (bn = 0; bn < n_bins; bn++) begin
                put_le($urandom, 4);
                n_chunks = $urandom_range(0, 2);
                if (flaw == FLAW_NEG_CHUNK) begin
                    put_le(neg_count, 4);
                    put_noise(6);
                    return;
                end
                put_le(n_chunks, 4);
                for (c = 0; c < n_chunks; c++) begin
                    put_le({$urandom, $urandom}, 8);
                    put_le({$urandom, $urandom}, 8);
                end
            end
            n_ints = $urandom_range(0, 3);
            if (flaw == FLAW_NEG_INT) begin
                put_le(neg_count, 4);
                put_noise(6);
                return;
            end
            put_le(n_ints, 4);
            for (c = 0; c < n_ints; c++) put_le({$urandom, $urandom}, 8);
        end
        if ($urandom_range(0, 1)) put_le({$urandom, $urandom}, 8);
    endtask

    // Random files until the beat budget of this phase is spent: mostly
    // well-formed, the rest spoiled in one of the ways above.
    task automatic run_random(input int budget);
        int    start;
        int    cut;
        int    idx;
        t_flaw flaw;
        start = beats_sent;
        while (beats_sent - start < budget) begin
            if ($urandom_range(0, 99) < 60) flaw = FLAW_NONE;
            else flaw = t_flaw'($urandom_range(FLAW_NEG_REF, FLAW_NOISE));
            build_index(flaw);
            case (flaw)
                FLAW_TRUNCATE: begin
                    cut = $urandom_range(0, file_bytes.size() - 1);
                    while (file_bytes.size() > cut) file_bytes.delete(file_bytes.size() - 1);
                end
                FLAW_TRAILING: begin
                    // the extra 8 bytes become the unplaced count if none was there
                    put_le({$urandom, $urandom}, 8);
                    put_noise(3);
                    add_byte(8'($urandom));
                end
                FLAW_MAGIC: begin
                    idx = $urandom_range(0, 3);
                    file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
                end
                FLAW_NOISE: begin
                    file_bytes.delete();
                    put_noise(24);
                end
                default: ;
            endcase
            send_file();
        end
    endtask

    // Receiver: random ready, plus a long hold-off on request so the parser
    // backs up and stalls its input.
    initial begin : receiver
        int k;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_rx_req) begin
                out_ready <= 1'b0;
                for (k = 0; k < RX_HOLD_CYCLES; k++) @(posedge clk);
                hold_rx_req = 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin : stimulus
        int i;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_mode  = 1'b0;
        in_byte  = 8'h00;
        tx_idle_pct = 11;
        rx_idle_pct = 47;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: end of file on an empty stream, then a header cut short.
        file_bytes.delete();
        send_file();
        file_bytes = '{8'h42, 8'h41};
        send_file();

        // Wrong third magic byte; the ninth byte must be dropped.
        file_bytes.delete();
        put_le(32'h0100_4142, 4);
        put_le(32'h0, 4);
        add_byte(8'hFF);
        send_file();

        // All-ones reference count is negative; the next byte is dropped.
        file_bytes.delete();
        put_le(BAI_MAGIC_LE, 4);
        put_le(32'hFFFF_FFFF, 4);
        add_byte(8'h00);
        send_file();

        // No references, all-ones unplaced count, then one trailing byte.
        file_bytes.delete();
        put_le(BAI_MAGIC_LE, 4);
        put_le(32'h0, 4);
        put_le('1, 8);
        add_byte(8'h00);
        send_file();

        // Random files under three idle patterns.
        run_random(PHASE_BEATS);
        tx_idle_pct = 47;
        rx_idle_pct = 11;
        run_random(PHASE_BEATS);
        tx_idle_pct = 0;
        rx_idle_pct = 0;

        // Back-pressure: one reference with a run of linear offsets while the
        // receiver holds off, so records pile up and input stalls.
        hold_rx_req = 1'b1;
        file_bytes.delete();
        put_le(BAI_MAGIC_LE, 4);
        put_le(32'd1, 4);
        put_le(32'd0, 4);
        put_le(32'd8, 4);
        for (i = 0; i < 8; i++) put_le({$urandom, $urandom}, 8);
        put_le({$urandom, $urandom}, 8);
        send_file();

        run_random(PHASE_BEATS);
        in_valid <= 1'b0;

        // Let the checker see the last acceptance, then drain.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d index files, %0d beats sent, %0d records checked",
                 files_sent, beats_sent, records_seen);
        $display("tb: covered magic, negative counts, truncation, trailing data, stalls");
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

endmodule
